FILE: src/tklet_pkg.sv
package tklet_pkg;

  localparam int TOP_SLOTS = 16;
  localparam int IDX_W = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;
  localparam int CNT_W = $clog2(TOP_SLOTS + 1);
  localparam int SEL_W = 4;
  localparam int CMP_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;
  localparam int IN_W = 488;
  localparam int OUT_W = 432;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic [63:0] length;
    logic [15:0] entry_point;
    logic [63:0] program_tag;
    logic [63:0] command_list_tag;
    logic [63:0] submission_tag;
    logic [63:0] event_tag;
    logic [63:0] stream_tag;
    logic [7:0]  queue_number;
    logic [7:0]  device_number;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    slot_t             data;
  } wr_t;

  typedef struct packed {
    logic              valid;
    logic [63:0]       length;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [63:0] finish_time;
    logic [63:0] begin_time;
    logic [15:0] entry_point;
    logic [63:0] program_tag;
    logic [63:0] command_list_tag;
    logic [63:0] submission_tag;
    logic [63:0] event_tag;
    logic [63:0] stream_tag;
    logic [7:0]  queue_number;
    logic [7:0]  device_number;
    logic [3:0]  slot_select;
  } item_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [63:0] read_length;
    logic [15:0] read_entry_point;
    logic [63:0] read_program;
    logic [63:0] read_command_list;
    logic [63:0] read_submission;
    logic [63:0] read_event;
    logic [63:0] read_stream;
    logic [7:0]  read_queue;
    logic [7:0]  read_device;
    logic [4:0]  filled_slots;
    logic [3:0]  slot_written;
    logic        taken;
  } result_t;

endpackage

FILE: src/tklet_cell.sv
module tklet_cell import tklet_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  wr_t              wr,
  input  logic [SEL_W-1:0] read_sel,
  input  cand_t            cand_in,
  output cand_t            cand_out,
  input  slot_t            rd_in,
  output slot_t            rd_out
);

  slot_t held;
  logic  sel_hit;

  assign sel_hit = (CMP_W'(cell_index) == CMP_W'(read_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      cand_out <= '0;
      rd_out <= '0;
    end else begin
      if (wr.en && (wr.idx == cell_index)) begin
        held <= wr.data;
      end
      // strict compare keeps the lowest index on ties
      if (!cand_in.valid || (held.length < cand_in.length)) begin
        cand_out <= '{valid: 1'b1, length: held.length, idx: cell_index};
      end else begin
        cand_out <= cand_in;
      end
      rd_out <= sel_hit ? held : rd_in;
    end
  end

endmodule

FILE: src/top_k_longest_event_tracker.sv
// a transaction accepted on s_* passes through S_SCAN and S_DONE; its result is registered onto m_*
// a new item is taken only once the last has left S_DONE, as the scan waits on the minimum and read-back
//   chains, which pass one cell per cycle through the row of slot cells
// the input side reopens while a finished result still waits on m_*
// rst is synchronous, active high: clears every slot, the fill count and the output
module top_k_longest_event_tracker import tklet_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // slot_select, device_number, queue_number, stream_tag, event_tag, submission_tag,
  // command_list_tag, program_tag, entry_point, begin_time, finish_time, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  // operation
  input  logic [0:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // taken, slot_written, filled_slots, read_device, read_queue, read_stream, read_event,
  // read_submission, read_command_list, read_program, read_entry_point, read_length,
  // zero pad
  output logic [OUT_W-1:0] m_tdata
);

  state_t state;
  state_t state_next;

  item_t item_in;
  item_t req;
  op_t   req_op;
  logic  rec_ok;
  logic [63:0] req_length;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] scan_cnt;
  logic             scan_last;
  logic             full;

  logic             accept;
  logic             done_go;
  logic             taken;
  logic [IDX_W-1:0] target;

  wr_t     wr;
  cand_t   cand [0:TOP_SLOTS];
  slot_t   rd   [0:TOP_SLOTS];
  result_t res;
  result_t out_data;
  logic    out_valid;

  logic [IDX_W+3:0] slot_ext;
  logic [CNT_W+4:0] cnt_ext;

  assign item_in = s_tdata;
  assign accept = s_tvalid && s_tready;
  assign full = (count == CNT_W'(TOP_SLOTS));
  assign scan_last = (scan_cnt == IDX_W'(TOP_SLOTS - 1));

  // row of slot cells
  assign cand[0] = '0;
  assign rd[0] = '0;

  for (genvar i = 0; i < TOP_SLOTS; i++) begin : g_cell
    tklet_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .wr         (wr),
      .read_sel   (req.slot_select),
      .cand_in    (cand[i]),
      .cand_out   (cand[i+1]),
      .rd_in      (rd[i]),
      .rd_out     (rd[i+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    done_go = 1'b0;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: ;
      S_DONE: done_go = !out_valid || m_tready;
      default: ;
    endcase
  end

  // slot decision
  always_comb begin
    taken = 1'b0;
    target = '0;
    count_next = count;
    if ((req_op == OP_RECORD) && rec_ok) begin
      if (!full) begin
        taken = 1'b1;
        target = count[IDX_W-1:0];
        count_next = CNT_W'(count + 1'b1);
      end else if (req_length > cand[TOP_SLOTS].length) begin
        taken = 1'b1;
        target = cand[TOP_SLOTS].idx;
      end
    end
  end

  always_comb begin
    wr.en = taken && done_go;
    wr.idx = target;
    wr.data.length = req_length;
    wr.data.entry_point = req.entry_point;
    wr.data.program_tag = req.program_tag;
    wr.data.command_list_tag = req.command_list_tag;
    wr.data.submission_tag = req.submission_tag;
    wr.data.event_tag = req.event_tag;
    wr.data.stream_tag = req.stream_tag;
    wr.data.queue_number = req.queue_number;
    wr.data.device_number = req.device_number;
  end

  assign slot_ext = {4'b0, target};
  assign cnt_ext = {5'b0, count_next};

  always_comb begin
    res = '0;
    res.taken = taken;
    res.slot_written = taken ? slot_ext[3:0] : 4'd0;
    res.filled_slots = cnt_ext[4:0];
    if (req_op == OP_READ) begin
      res.read_length = rd[TOP_SLOTS].length;
      res.read_entry_point = rd[TOP_SLOTS].entry_point;
      res.read_program = rd[TOP_SLOTS].program_tag;
      res.read_command_list = rd[TOP_SLOTS].command_list_tag;
      res.read_submission = rd[TOP_SLOTS].submission_tag;
      res.read_event = rd[TOP_SLOTS].event_tag;
      res.read_stream = rd[TOP_SLOTS].stream_tag;
      res.read_queue = rd[TOP_SLOTS].queue_number;
      res.read_device = rd[TOP_SLOTS].device_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      scan_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= IDX_W'(scan_cnt + 1'b1);
      end else begin
        scan_cnt <= '0;
      end
      if (done_go) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item_in;
      req_op <= op_t'(s_tuser[0]);
      rec_ok <= (item_in.begin_time != 64'd0) && (item_in.finish_time != 64'd0) &&
                (item_in.finish_time >= item_in.begin_time);
      req_length <= item_in.finish_time - item_in.begin_time;
    end
    if (done_go) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TOP_SLOTS))
    else $error("fill count beyond table size");

  a_write_in_done: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_DONE))
    else $error("slot write outside decision cycle");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(count))
    else $error("fill count changed outside decision cycle");

  a_fill_in_order: assert property (@(posedge clk) disable iff (rst)
    (wr.en && !full) |-> (wr.idx == count[IDX_W-1:0]))
    else $error("fill write not at next free slot");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN))
    else $error("accepted transaction did not start a scan");

endmodule
